### rtl/core/stsi_pkg.sv
//------------------------------------------------------------------------------
// stsi_pkg
// Shared types, constants and character helpers for the string to signed
// integer converter.
//------------------------------------------------------------------------------
`default_nettype none

package stsi_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned BASE_W   = 6;
	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned OFFSET_W = 16;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX = 16'hFFFF;

	localparam logic [VALUE_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [VALUE_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;

	localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
	localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
	localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BAD_DIGIT  = 6'd36;

	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

	typedef enum logic [5:0] {
		PH_DONE   = 6'b000001,
		PH_LEAD   = 6'b000010,
		PH_SIGNED = 6'b000100,
		PH_ZERO   = 6'b001000,
		PH_PREFIX = 6'b010000,
		PH_DIGITS = 6'b100000
	} phase_t;

	function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			d = c - CH_ZERO;
		end else if (c inside {[CH_UA:CH_UZ]}) begin
			d = c - CH_UA + 8'd10;
		end else if (c inside {[CH_LA:CH_LZ]}) begin
			d = c - CH_LA + 8'd10;
		end else begin
			d = {2'b00, BAD_DIGIT};
		end
		return d[BASE_W-1:0];
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

	function automatic logic valid_in(input logic [CHAR_W-1:0] c,
			input logic [BASE_W-1:0] base);
		return (base >= BASE_MIN) && (base <= BASE_MAX) && (digit_of(c) < base);
	endfunction

endpackage

`default_nettype wire

### rtl/core/stsi_ifs.sv
//------------------------------------------------------------------------------
// stsi_ifs
// Valid/ready channels: characters in, conversion results out.
//------------------------------------------------------------------------------
`default_nettype none

interface stsi_char_if;
	import stsi_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              start_flag;

	modport source (output valid, char_code, start_flag, input ready);
	modport sink   (input valid, char_code, start_flag, output ready);
endinterface

interface stsi_result_if;
	import stsi_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      range_error;
	logic                      no_digits;
	logic [OFFSET_W-1:0]       end_offset;

	modport source (output valid, value, range_error, no_digits, end_offset, input ready);
	modport sink   (input valid, value, range_error, no_digits, end_offset, output ready);
endinterface

`default_nettype wire

### rtl/core/string_to_signed_integer_top.sv
//------------------------------------------------------------------------------
// string_to_signed_integer_top
// Character-serial strtol: signed 64-bit conversion with saturation.
//------------------------------------------------------------------------------
// Usage:
//   char_stream carries one character per item; start_flag marks the first
//   character of a string. After optional whitespace and sign, digits in the
//   configured base (cfg_we/cfg_wdata; 0 = auto from prefix) build the value.
//   The first character outside the number produces one item on
//   result_stream; later characters are dropped until the next start_flag.
//   Throughput: one character per cycle unless a held result stalls it. The
//   multiply-add by the base and its saturation compare are combinational on the state.
//   A terminating character passes the input register, then the result
//   register, before it appears as a result; a held result can stall it.
//   Stall: a held result stops the input register; char_stream.ready drops
//   while a character waits in the input register and the result slot is
//   occupied and not being taken this cycle.
//   Reset: base returns to 10, no string is active, both registers empty.
//   Base writes belong between strings.
//------------------------------------------------------------------------------
`default_nettype none

module string_to_signed_integer_top #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [stsi_pkg::BASE_W-1:0]  cfg_wdata,
	stsi_char_if.sink                         char_stream,
	stsi_result_if.source                     result_stream
);
	import stsi_pkg::*;

	localparam int unsigned EXT_W  = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;
	localparam int unsigned PROD_W = VALUE_W + BASE_W + 1;

	function automatic logic [POSITION_BITS-1:0] pos_inc(
			input logic [POSITION_BITS-1:0] p);
		return (&p) ? p : p + 1'b1;
	endfunction

	logic [BASE_W-1:0] number_base_q;

	logic              s1_valid_q;
	logic [CHAR_W-1:0] char_s1;
	logic              start_s1;

	phase_t                   phase_q;
	logic                     neg_q;
	logic [VALUE_W-1:0]       acc_q;
	logic                     ovf_q;
	logic [BASE_W-1:0]        base_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] endpos_q;
	logic                     seen_q;

	phase_t                   cur_phase, nxt_phase;
	logic                     cur_neg, nxt_neg;
	logic [VALUE_W-1:0]       cur_acc, nxt_acc;
	logic                     cur_ovf, nxt_ovf;
	logic [BASE_W-1:0]        cur_base, nxt_base;
	logic [POSITION_BITS-1:0] cur_pos, nxt_pos;
	logic [POSITION_BITS-1:0] cur_endpos, nxt_endpos;
	logic                     cur_seen, nxt_seen;

	logic               first, dig_try, take, fire;
	logic [BASE_W-1:0]  dig;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  limit;
	logic [EXT_W-1:0]   endpos_ext;

	logic signed [VALUE_W-1:0] res_value;
	logic                      res_range;
	logic                      res_nodig;
	logic [OFFSET_W-1:0]       res_offset;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      range_q;
	logic                      nodig_q;
	logic [OFFSET_W-1:0]       offset_q;

	logic advance;

	assign advance           = s1_valid_q && (!out_valid_q || result_stream.ready);
	assign char_stream.ready = !s1_valid_q || advance;

	always_comb begin
		cur_phase  = start_s1 ? PH_LEAD : phase_q;
		cur_neg    = start_s1 ? 1'b0 : neg_q;
		cur_acc    = start_s1 ? '0 : acc_q;
		cur_ovf    = start_s1 ? 1'b0 : ovf_q;
		cur_base   = start_s1 ? '0 : base_q;
		cur_pos    = start_s1 ? '0 : pos_q;
		cur_endpos = start_s1 ? '0 : endpos_q;
		cur_seen   = start_s1 ? 1'b0 : seen_q;

		nxt_phase  = cur_phase;
		nxt_neg    = cur_neg;
		nxt_acc    = cur_acc;
		nxt_ovf    = cur_ovf;
		nxt_base   = cur_base;
		nxt_endpos = cur_endpos;
		nxt_seen   = cur_seen;
		nxt_pos    = (cur_phase == PH_DONE) ? cur_pos : pos_inc(cur_pos);

		first   = 1'b0;
		dig_try = 1'b0;
		take    = 1'b0;
		fire    = 1'b0;

		case (cur_phase)
			PH_LEAD: begin
				if (is_space(char_s1)) begin
					nxt_phase = PH_LEAD;
				end else if (char_s1 == CH_MINUS) begin
					nxt_neg   = 1'b1;
					nxt_phase = PH_SIGNED;
				end else if (char_s1 == CH_PLUS) begin
					nxt_phase = PH_SIGNED;
				end else begin
					first = 1'b1;
				end
			end
			PH_SIGNED: begin
				first = 1'b1;
			end
			PH_ZERO: begin
				if (char_s1 == CH_LX || char_s1 == CH_UX) begin
					nxt_base  = BASE_HEX;
					nxt_phase = PH_PREFIX;
				end else begin
					dig_try = 1'b1;
				end
			end
			PH_PREFIX: begin
				if (valid_in(char_s1, BASE_HEX)) begin
					take      = 1'b1;
					nxt_phase = PH_DIGITS;
				end else begin
					fire = 1'b1;
				end
			end
			PH_DIGITS: begin
				dig_try = 1'b1;
			end
			default: begin
				nxt_phase = PH_DONE;
			end
		endcase

		// first character after whitespace/sign latches the base
		if (first) begin
			if (char_s1 == CH_ZERO &&
					(number_base_q == BASE_AUTO || number_base_q == BASE_HEX)) begin
				nxt_base   = (number_base_q == BASE_AUTO) ? BASE_OCT : BASE_HEX;
				nxt_seen   = 1'b1;
				nxt_endpos = pos_inc(cur_pos);
				nxt_phase  = PH_ZERO;
			end else begin
				nxt_base = (number_base_q == BASE_AUTO) ? BASE_DEC : number_base_q;
				dig_try  = 1'b1;
			end
		end

		if (dig_try) begin
			if (valid_in(char_s1, nxt_base)) begin
				take      = 1'b1;
				nxt_phase = PH_DIGITS;
			end else begin
				fire = 1'b1;
			end
		end

		if (fire) begin
			nxt_phase = PH_DONE;
		end

		dig   = digit_of(char_s1);
		prod  = PROD_W'(cur_acc) * PROD_W'(nxt_base) + PROD_W'(dig);
		limit = cur_neg ? PROD_W'(VALUE_MIN) : PROD_W'(VALUE_MAX);
		if (take) begin
			if (!cur_ovf) begin
				if (prod > limit) begin
					nxt_ovf = 1'b1;
				end else begin
					nxt_acc = prod[VALUE_W-1:0];
				end
			end
			nxt_seen   = 1'b1;
			nxt_endpos = pos_inc(cur_pos);
		end

		endpos_ext = EXT_W'(cur_endpos);
		if (!cur_seen) begin
			res_value  = '0;
			res_range  = 1'b0;
			res_nodig  = 1'b1;
			res_offset = '0;
		end else begin
			if (cur_ovf) begin
				res_value = cur_neg ? VALUE_MIN : VALUE_MAX;
			end else begin
				res_value = cur_neg ? -cur_acc : cur_acc;
			end
			res_range  = cur_ovf;
			res_nodig  = 1'b0;
			res_offset = (endpos_ext > EXT_W'(OFFSET_MAX)) ? OFFSET_MAX
				: endpos_ext[OFFSET_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_RESET;
			s1_valid_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			phase_q       <= PH_DONE;
			neg_q         <= 1'b0;
			acc_q         <= '0;
			ovf_q         <= 1'b0;
			base_q        <= '0;
			pos_q         <= '0;
			endpos_q      <= '0;
			seen_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				number_base_q <= cfg_wdata;
			end
			if (char_stream.ready) begin
				s1_valid_q <= char_stream.valid;
			end
			if (advance) begin
				phase_q  <= nxt_phase;
				neg_q    <= nxt_neg;
				acc_q    <= nxt_acc;
				ovf_q    <= nxt_ovf;
				base_q   <= nxt_base;
				pos_q    <= nxt_pos;
				endpos_q <= nxt_endpos;
				seen_q   <= nxt_seen;
			end
			if (advance && fire) begin
				out_valid_q <= 1'b1;
			end else if (result_stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_stream.ready && char_stream.valid) begin
			char_s1  <= char_stream.char_code;
			start_s1 <= char_stream.start_flag;
		end
		if (advance && fire) begin
			value_q  <= res_value;
			range_q  <= res_range;
			nodig_q  <= res_nodig;
			offset_q <= res_offset;
		end
	end

	assign result_stream.valid       = out_valid_q;
	assign result_stream.value       = value_q;
	assign result_stream.range_error = range_q;
	assign result_stream.no_digits   = nodig_q;
	assign result_stream.end_offset  = offset_q;

endmodule

`default_nettype wire

### rtl/core/stsi_checker.sv
//------------------------------------------------------------------------------
// stsi_checker
// Port-level checks for the string to signed integer converter.
//------------------------------------------------------------------------------
`default_nettype none

module stsi_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_ready,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic signed [stsi_pkg::VALUE_W-1:0] value,
	input wire logic                                range_error,
	input wire logic                                no_digits,
	input wire logic [stsi_pkg::OFFSET_W-1:0]       end_offset
);
	import stsi_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(range_error)
			&& $stable(no_digits) && $stable(end_offset))
		else $error("result item changed while stalled");

	a_no_digits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_digits |-> value == '0 && !range_error && end_offset == '0)
		else $error("no-digit result carries nonzero fields");

	a_range_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> value == VALUE_MAX || value == VALUE_MIN)
		else $error("range error without saturated value");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result slot");

endmodule

bind string_to_signed_integer_top stsi_checker u_stsi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (char_stream.ready),
	.out_valid   (result_stream.valid),
	.out_ready   (result_stream.ready),
	.value       (result_stream.value),
	.range_error (result_stream.range_error),
	.no_digits   (result_stream.no_digits),
	.end_offset  (result_stream.end_offset)
);

`default_nettype wire

### bench/stsi_conversion_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// stsi_conversion_checker
// Watches the character and result channels of the string to signed integer
// converter. Parses every accepted item as the converter should, queues the
// numbers it closes, and compares each result item with the oldest one.
//------------------------------------------------------------------------------

module stsi_conversion_checker
	import stsi_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [BASE_W-1:0]         cfg_wdata,
	input  logic                      char_valid,
	input  logic                      char_ready,
	input  logic [CHAR_W-1:0]         char_code,
	input  logic                      start_flag,
	input  logic                      result_valid,
	input  logic                      result_ready,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      range_error,
	input  logic                      no_digits,
	input  logic [OFFSET_W-1:0]       end_offset,
	output int unsigned               fail_count,
	output int unsigned               numbers_waiting,
	output int unsigned               numbers_checked
);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      range_error;
		logic                      no_digits;
		logic [OFFSET_W-1:0]       end_offset;
	} number_t;

	logic [BASE_W-1:0]   base_reg;
	logic [BASE_W-1:0]   radix;
	phase_t              phase;
	logic                minus;
	logic                saturated;
	logic                any_digit;
	logic [VALUE_W-1:0]  magnitude;
	logic [OFFSET_W-1:0] pos;
	logic [OFFSET_W-1:0] end_pos;
	number_t             parsed_q[$];

	function automatic logic [BASE_W-1:0] char_weight(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] w;
		w = {2'b00, BAD_DIGIT};
		if (c >= CH_ZERO && c <= CH_NINE) begin
			w = c - CH_ZERO;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			w = c - CH_UA + 8'd10;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			w = c - CH_LA + 8'd10;
		end
		return w[BASE_W-1:0];
	endfunction

	function automatic logic takes(input logic [CHAR_W-1:0] c, input logic [BASE_W-1:0] b);
		return (b >= BASE_MIN) && (b <= BASE_MAX) && (char_weight(c) < b);
	endfunction

	function automatic logic [OFFSET_W-1:0] step_pos(input logic [OFFSET_W-1:0] p);
		return (p == OFFSET_MAX) ? p : p + 1'b1;
	endfunction

	task automatic close_number(output number_t n);
		phase = PH_DONE;
		n = '0;
		if (!any_digit) begin
			n.no_digits = 1'b1;
		end else begin
			if (saturated) begin
				n.value = minus ? VALUE_MIN : VALUE_MAX;
			end else begin
				n.value = minus ? -magnitude : magnitude;
			end
			n.range_error = saturated;
			n.end_offset = end_pos;
		end
	endtask

	task automatic add_digit(input logic [BASE_W-1:0] d);
		logic [VALUE_W-1:0] lim;
		lim = minus ? VALUE_MIN : VALUE_MAX;
		if (!saturated) begin
			if (magnitude > (lim - d) / radix) begin
				saturated = 1'b1;
			end else begin
				magnitude = magnitude * radix + d;
			end
		end
		any_digit = 1'b1;
		end_pos = step_pos(pos);
	endtask

	task automatic digit_or_close(input logic [CHAR_W-1:0] c, output logic got,
			output number_t n);
		got = 1'b0;
		n = '0;
		if (takes(c, radix)) begin
			add_digit(char_weight(c));
			phase = PH_DIGITS;
		end else begin
			close_number(n);
			got = 1'b1;
		end
	endtask

	// radix is latched here, at the first character past the sign
	task automatic first_char(input logic [CHAR_W-1:0] c, output logic got, output number_t n);
		got = 1'b0;
		n = '0;
		if (c == CH_ZERO && (base_reg == BASE_AUTO || base_reg == BASE_HEX)) begin
			radix = (base_reg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
			any_digit = 1'b1;
			end_pos = step_pos(pos);
			phase = PH_ZERO;
		end else begin
			radix = (base_reg == BASE_AUTO) ? BASE_DEC : base_reg;
			digit_or_close(c, got, n);
		end
	endtask

	task automatic parse_char(input logic [CHAR_W-1:0] c, input logic st, output logic got,
			output number_t n);
		got = 1'b0;
		n = '0;
		if (st) begin
			phase = PH_LEAD;
			minus = 1'b0;
			magnitude = '0;
			saturated = 1'b0;
			radix = '0;
			pos = '0;
			end_pos = '0;
			any_digit = 1'b0;
		end
		case (phase)
			PH_LEAD: begin
				if (c == CH_MINUS) begin
					minus = 1'b1;
					phase = PH_SIGNED;
				end else if (c == CH_PLUS) begin
					phase = PH_SIGNED;
				end else if (c != CH_SPACE && (c < CH_TAB || c > CH_CR)) begin
					first_char(c, got, n);
				end
			end
			PH_SIGNED: begin
				first_char(c, got, n);
			end
			PH_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					radix = BASE_HEX;
					phase = PH_PREFIX;
				end else begin
					digit_or_close(c, got, n);
				end
			end
			PH_PREFIX: begin
				if (takes(c, BASE_HEX)) begin
					add_digit(char_weight(c));
					phase = PH_DIGITS;
				end else begin
					close_number(n);
					got = 1'b1;
				end
			end
			PH_DIGITS: begin
				digit_or_close(c, got, n);
			end
			default: begin
				phase = PH_DONE;
			end
		endcase
		pos = step_pos(pos);
	endtask

	always @(posedge clk or negedge arst_n) begin
		number_t oldest;
		number_t fresh;
		logic    got;
		if (!arst_n) begin
			base_reg = BASE_RESET;
			phase = PH_DONE;
			minus = 1'b0;
			magnitude = '0;
			saturated = 1'b0;
			radix = '0;
			pos = '0;
			end_pos = '0;
			any_digit = 1'b0;
			parsed_q.delete();
			fail_count = 0;
			numbers_waiting = 0;
			numbers_checked = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (parsed_q.size() == 0) begin
					$error("result item with no number pending: value %0d", value);
					fail_count++;
				end else begin
					oldest = parsed_q.pop_front();
					numbers_checked++;
					if (value !== oldest.value) begin
						$error("value: expected %0d, got %0d", oldest.value, value);
						fail_count++;
					end
					if (range_error !== oldest.range_error) begin
						$error("range_error: expected %0b, got %0b", oldest.range_error,
							range_error);
						fail_count++;
					end
					if (no_digits !== oldest.no_digits) begin
						$error("no_digits: expected %0b, got %0b", oldest.no_digits, no_digits);
						fail_count++;
					end
					if (end_offset !== oldest.end_offset) begin
						$error("end_offset: expected %0d, got %0d", oldest.end_offset,
							end_offset);
						fail_count++;
					end
				end
			end
			if (char_valid && char_ready) begin
				parse_char(char_code, start_flag, got, fresh);
				if (got) begin
					parsed_q.push_back(fresh);
				end
			end
			if (cfg_we) begin
				base_reg = cfg_wdata;
			end
			numbers_waiting = parsed_q.size();
		end
	end

endmodule

### bench/string_to_signed_integer_top_test.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// string_to_signed_integer_top_test
// Feeds the converter strings of characters: a short directed set for the
// prefix, sign, base and restart cases, then random well-formed numbers,
// noise and broken strings under changing radixes. Both channels stall at
// random in changing ratios; a separate checker predicts and compares every
// result item.
//------------------------------------------------------------------------------

module string_to_signed_integer_top_test;
	import stsi_pkg::*;

	localparam int unsigned QUIET_LIMIT = 3000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [BASE_W-1:0] cfg_wdata;

	stsi_char_if   chars ();
	stsi_result_if results ();

	int unsigned       send_idle_pct;
	int unsigned       recv_idle_pct;
	int unsigned       fail_count;
	int unsigned       numbers_waiting;
	int unsigned       numbers_checked;
	int unsigned       chars_sent;
	int unsigned       strings_sent;
	int unsigned       base_writes;
	int unsigned       quiet_cycles;
	logic [BASE_W-1:0] base_now;
	logic              lead_flag;

	string_to_signed_integer_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.char_stream   (chars),
		.result_stream (results)
	);

	stsi_conversion_checker number_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.char_valid      (chars.valid),
		.char_ready      (chars.ready),
		.char_code       (chars.char_code),
		.start_flag      (chars.start_flag),
		.result_valid    (results.valid),
		.result_ready    (results.ready),
		.value           (results.value),
		.range_error     (results.range_error),
		.no_digits       (results.no_digits),
		.end_offset      (results.end_offset),
		.fail_count      (fail_count),
		.numbers_waiting (numbers_waiting),
		.numbers_checked (numbers_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		results.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((chars.valid && chars.ready) || (results.valid && results.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// called just after a falling edge; leaves valid high for a following item
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic st);
		logic took;
		while ($urandom_range(99) < send_idle_pct) begin
			chars.valid = 1'b0;
			@(negedge clk);
		end
		chars.valid = 1'b1;
		chars.char_code = c;
		chars.start_flag = st;
		do begin
			@(posedge clk);
			took = chars.ready;
		end while (!took);
		chars_sent++;
		if (st) begin
			strings_sent++;
		end
		@(negedge clk);
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] c);
		send_char(c, lead_flag);
		lead_flag = 1'b0;
	endtask

	task automatic write_base(input logic [BASE_W-1:0] b);
		chars.valid = 1'b0;
		while (numbers_waiting != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = b;
		@(negedge clk);
		cfg_we = 1'b0;
		base_now = b;
		base_writes++;
	endtask

	function automatic logic [BASE_W-1:0] pick_base();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15) begin
			return BASE_AUTO;
		end else if (r < 30) begin
			return BASE_DEC;
		end else if (r < 45) begin
			return BASE_HEX;
		end else if (r < 55) begin
			return BASE_MIN;
		end else if (r < 65) begin
			return BASE_MAX;
		end else if (r < 72) begin
			return BASE_OCT;
		end else if (r < 78) begin
			return $urandom_range(1) ? 6'd1 : 6'($urandom_range(37, 63));
		end
		return 6'($urandom_range(2, 36));
	endfunction

	function automatic logic [CHAR_W-1:0] rand_digit(input int unsigned b);
		int unsigned d;
		d = $urandom_range(b - 1);
		if (d < 10) begin
			return CH_ZERO + 8'(d);
		end
		return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(d - 10);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_space();
		if ($urandom_range(5) == 0) begin
			return CH_SPACE;
		end
		return CH_TAB + 8'($urandom_range(4));
	endfunction

	task automatic send_random_string();
		int unsigned b;
		int unsigned ndig;
		string       limit_hex;
		lead_flag = 1'b1;
		if ($urandom_range(99) < 15) begin
			// noise, with a restart now and then
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(7) == 0) begin
					lead_flag = 1'b1;
				end
				put_char(8'($urandom_range(255)));
			end
		end else begin
			repeat ($urandom_range(2)) put_char(rand_space());
			case ($urandom_range(2))
				1: put_char(CH_PLUS);
				2: put_char(CH_MINUS);
				default: ;
			endcase
			b = (base_now >= BASE_MIN && base_now <= BASE_MAX) ? base_now : 10;
			if (base_now == BASE_AUTO || base_now == BASE_HEX) begin
				case ($urandom_range(2))
					0: begin
						put_char(CH_ZERO);
						put_char($urandom_range(1) ? CH_LX : CH_UX);
						b = 16;
					end
					1: begin
						if (base_now == BASE_AUTO) begin
							put_char(CH_ZERO);
							b = 8;
						end
					end
					default: ;
				endcase
			end
			if (b == 16 && $urandom_range(7) == 0) begin
				case ($urandom_range(3))
					0: limit_hex = "7fffffffffffffff";
					1: limit_hex = "8000000000000000";
					2: limit_hex = "8000000000000001";
					default: limit_hex = "FFFFFFFFFFFFFFFF";
				endcase
				for (int i = 0; i < limit_hex.len(); i++) begin
					put_char(limit_hex[i]);
				end
			end else begin
				ndig = ($urandom_range(3) == 0) ? $urandom_range(15, 70) : $urandom_range(0, 14);
				repeat (ndig) put_char(rand_digit(b));
			end
			case ($urandom_range(3))
				0: put_char(8'h00);
				1: put_char(CH_SPACE);
				2: put_char(8'($urandom_range(255)));
				default: ;
			endcase
			if ($urandom_range(4) == 0) begin
				repeat ($urandom_range(1, 2)) put_char(8'($urandom_range(255)));
			end
		end
	endtask

	task automatic random_until(input int unsigned target);
		while (chars_sent < target) begin
			write_base(pick_base());
			repeat ($urandom_range(6, 14)) begin
				if (chars_sent < target) begin
					send_random_string();
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = BASE_RESET;
		chars.valid = 1'b0;
		chars.char_code = '0;
		chars.start_flag = 1'b0;
		send_idle_pct = 27;
		recv_idle_pct = 75;
		chars_sent = 0;
		strings_sent = 0;
		base_writes = 0;
		base_now = BASE_RESET;
		lead_flag = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// whitespace, sign, NUL end, then an ignored trailing item
		lead_flag = 1'b1;
		put_char(CH_SPACE);
		put_char(CH_TAB);
		put_char(CH_MINUS);
		put_char("4");
		put_char("2");
		put_char(8'h00);
		put_char(8'hFF);
		// sign with no digits
		lead_flag = 1'b1;
		put_char(CH_PLUS);
		put_char(8'hFF);
		// restart drops the open string
		lead_flag = 1'b1;
		put_char("9");
		lead_flag = 1'b1;
		put_char("7");
		put_char(CH_SPACE);
		// base written mid-string only affects the next string
		lead_flag = 1'b1;
		put_char("1");
		put_char("2");
		write_base(BASE_HEX);
		put_char("a");
		lead_flag = 1'b1;
		put_char("a");
		put_char(8'h00);
		// auto base: 0x with no hex digit, then octal
		write_base(BASE_AUTO);
		lead_flag = 1'b1;
		put_char(CH_ZERO);
		put_char(CH_LX);
		put_char("g");
		lead_flag = 1'b1;
		put_char(CH_ZERO);
		put_char("7");
		put_char("8");
		write_base(6'd1);
		lead_flag = 1'b1;
		put_char("5");
		write_base(BASE_MAX);
		lead_flag = 1'b1;
		put_char(CH_UZ);
		put_char(CH_LZ);
		put_char(8'h00);
		write_base(6'd63);
		lead_flag = 1'b1;
		put_char("1");

		random_until(520);
		send_idle_pct = 75;
		recv_idle_pct = 27;
		random_until(1040);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_until(1550);
		chars.valid = 1'b0;

		while (numbers_waiting != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
		$display("Sent %0d strings in %0d characters under %0d radix settings",
			strings_sent, chars_sent, base_writes);
		$display("(automatic, 2 to 36, invalid); %0d result items checked.", numbers_checked);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
